### sv/mrkfp_pkg.sv
// ----------------------------------------------------------------------------
// mrkfp_pkg
// Types and constants shared by the multi-recipient key frame parser.
// ----------------------------------------------------------------------------
package mrkfp_pkg;

  // Default for the top-level recipient limit.
  localparam int MAX_RECIPIENTS_DEF = 25;

  // Fixed framing constants.
  localparam int MAX_NAME_CHARS = 14;
  localparam int STATION_CHARS  = 14;
  localparam int IV_BYTES       = 12;
  localparam int TAG_BYTES      = 16;
  localparam int HDR_BYTES      = 8;
  localparam logic [7:0] VERSION_ID = 8'h01;
  localparam logic [7:0] CIPHER_ID  = 8'h01;
  localparam logic [7:0] ASCII_MAX  = 8'd127;

  // Configuration port geometry: 64-bit registers at 8-byte spacing.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  typedef enum logic [1:0] {
    REG_CURVE_ID  = 2'd0,
    REG_NAME_LEN  = 2'd1,
    REG_NAME_LOW  = 2'd2,
    REG_NAME_HIGH = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    CLS_HEADER     = 3'd0,
    CLS_FRAMING    = 3'd1,
    CLS_OWN_FRAG   = 3'd2,
    CLS_OTHER_FRAG = 3'd3,
    CLS_IV         = 3'd4,
    CLS_CIPHER     = 3'd5,
    CLS_TAG        = 3'd6,
    CLS_DISCARD    = 3'd7
  } byte_class_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SHORT       = 4'd1,
    ST_BAD_HEADER  = 4'd2,
    ST_CURVE       = 4'd3,
    ST_TRUNCATED   = 4'd4,
    ST_NAME_LENGTH = 4'd5,
    ST_NON_ASCII   = 4'd6,
    ST_TERMINATOR  = 4'd7,
    ST_NO_MATCH    = 4'd8,
    ST_TAIL_LENGTH = 4'd9,
    ST_DATA_SHORT  = 4'd10
  } status_t;

  typedef struct packed {
    logic [1:0]                       curve_id;
    logic [3:0]                       name_len;
    logic [STATION_CHARS-1:0][7:0]    name;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    byte_class_t byte_class;
    logic [4:0]  recipient_index;
    logic        done_res;
    status_t     status;
    logic [4:0]  matched_index;
    logic [31:0] data_length;
  } result_t;

endpackage

### sv/mrkfp_ifs.sv
// ----------------------------------------------------------------------------
// mrkfp stream interfaces
// Valid/ready channels for message bytes in and labeled bytes out.
// ----------------------------------------------------------------------------
interface mrkfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;
  logic       last_byte;

  modport source (output valid, output wire_byte, output last_byte, input ready);
  modport sink   (input valid, input wire_byte, input last_byte, output ready);
endinterface

interface mrkfp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [2:0]  byte_class;
  logic [4:0]  recipient_index;
  logic        done_res;
  logic [3:0]  status;
  logic [4:0]  matched_index;
  logic [31:0] data_length;

  modport source (output valid, output byte_out, output byte_class,
                  output recipient_index, output done_res, output status,
                  output matched_index, output data_length, input ready);
  modport sink   (input valid, input byte_out, input byte_class,
                  input recipient_index, input done_res, input status,
                  input matched_index, input data_length, output ready);
endinterface

### sv/mrkfp_parse_core.sv
// ----------------------------------------------------------------------------
// mrkfp_parse_core
// Per-message parse state and the one-byte labeling step.
// ----------------------------------------------------------------------------
module mrkfp_parse_core #(
  parameter int MAX_RECIPIENTS = mrkfp_pkg::MAX_RECIPIENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         wire_byte,
  input  logic               last_byte,
  input  mrkfp_pkg::cfg_t    cfg,
  output mrkfp_pkg::result_t res
);

  localparam int CW = $clog2(MAX_RECIPIENTS + 1);
  localparam int IW = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    PH_HDR, PH_LEN, PH_NAME, PH_TERM, PH_FHI, PH_FLO, PH_FRAG, PH_TAIL
  } phase_t;

  phase_t             phase, phase_next;
  logic [3:0]         fcnt, fcnt_next;
  logic [CW-1:0]      total, total_next;
  logic [CW-1:0]      seen, seen_next;
  logic [31:0]        hlv, hlv_next;
  logic [3:0]         nlen, nlen_next;
  logic               neq, neq_next;
  logic [15:0]        frem, frem_next;
  logic [32:0]        tail, tail_next;
  logic               mseen, mseen_next;
  logic [CW-1:0]      midx, midx_next;
  mrkfp_pkg::status_t err, err_next;

  mrkfp_pkg::byte_class_t cls;
  logic [CW-1:0]      ridx;
  logic               fin;
  logic [1:0]         curve_eff;
  logic [7:0]         up_char;
  logic [15:0][7:0]   name_pad;
  logic               st_ok;
  logic [3:0]         fcnt_inc;
  logic [32:0]        tag_end;
  mrkfp_pkg::status_t sts;
  logic [IW-1:0]      ridx_ext, midx_ext;

  assign curve_eff = (cfg.curve_id == 2'd0) ? 2'd1 : cfg.curve_id;
  assign name_pad  = {16'h0, cfg.name};
  assign st_ok     = (fcnt < 4'(mrkfp_pkg::STATION_CHARS));
  assign fcnt_inc  = fcnt + 4'd1;
  assign up_char   = (wire_byte >= 8'h61 && wire_byte <= 8'h7A) ? wire_byte - 8'h20
                                                               : wire_byte;
  assign tag_end   = 33'(hlv) + 33'(mrkfp_pkg::TAG_BYTES);

  always_comb begin
    phase_next = phase;
    fcnt_next  = fcnt;
    total_next = total;
    seen_next  = seen;
    hlv_next   = hlv;
    nlen_next  = nlen;
    neq_next   = neq;
    frem_next  = frem;
    tail_next  = tail;
    mseen_next = mseen;
    midx_next  = midx;
    err_next   = err;
    cls        = mrkfp_pkg::CLS_DISCARD;
    ridx       = '0;
    fin        = 1'b0;

    if (phase == PH_HDR) begin
      cls = mrkfp_pkg::CLS_HEADER;
      unique case (fcnt)
        4'd0: begin
          if (wire_byte != mrkfp_pkg::VERSION_ID) err_next = mrkfp_pkg::ST_BAD_HEADER;
        end
        4'd1: begin
          if (wire_byte != {6'b0, curve_eff} && err == mrkfp_pkg::ST_OK)
            err_next = mrkfp_pkg::ST_CURVE;
        end
        4'd2: begin
          total_next = CW'(wire_byte);
          if (wire_byte == 8'd0 || {1'b0, wire_byte} > 9'(MAX_RECIPIENTS))
            err_next = mrkfp_pkg::ST_BAD_HEADER;
        end
        4'd3: begin
          if (wire_byte != mrkfp_pkg::CIPHER_ID) err_next = mrkfp_pkg::ST_BAD_HEADER;
        end
        default: hlv_next = {hlv[23:0], wire_byte};
      endcase
      if (fcnt == 4'(mrkfp_pkg::HDR_BYTES - 1)) begin
        fcnt_next  = '0;
        phase_next = PH_LEN;
      end else begin
        fcnt_next = fcnt_inc;
      end
    end else if (err == mrkfp_pkg::ST_OK) begin
      unique case (phase)
        PH_LEN: begin
          cls  = mrkfp_pkg::CLS_FRAMING;
          ridx = seen;
          if (wire_byte == 8'd0 || wire_byte > 8'(mrkfp_pkg::MAX_NAME_CHARS)) begin
            err_next = mrkfp_pkg::ST_NAME_LENGTH;
          end else begin
            nlen_next  = wire_byte[3:0];
            neq_next   = 1'b1;
            fcnt_next  = '0;
            phase_next = PH_NAME;
          end
        end
        PH_NAME: begin
          cls  = mrkfp_pkg::CLS_FRAMING;
          ridx = seen;
          if (wire_byte > mrkfp_pkg::ASCII_MAX) begin
            err_next = mrkfp_pkg::ST_NON_ASCII;
          end else begin
            if (!st_ok || up_char != name_pad[fcnt]) neq_next = 1'b0;
            fcnt_next = fcnt_inc;
            if (fcnt_inc >= nlen) phase_next = PH_TERM;
          end
        end
        PH_TERM: begin
          cls  = mrkfp_pkg::CLS_FRAMING;
          ridx = seen;
          if (wire_byte != 8'd0) err_next = mrkfp_pkg::ST_TERMINATOR;
          else phase_next = PH_FHI;
        end
        PH_FHI: begin
          cls        = mrkfp_pkg::CLS_FRAMING;
          ridx       = seen;
          frem_next  = {wire_byte, 8'h00};
          phase_next = PH_FLO;
        end
        PH_FLO: begin
          cls       = mrkfp_pkg::CLS_FRAMING;
          ridx      = seen;
          frem_next = {frem[15:8], wire_byte};
          if (frem_next != 16'd0 && cfg.name_len != 4'd0 &&
              nlen == cfg.name_len && neq) begin
            mseen_next = 1'b1;
            midx_next  = seen;
          end
          if (frem_next == 16'd0) fin = 1'b1;
          else phase_next = PH_FRAG;
        end
        PH_FRAG: begin
          ridx      = seen;
          cls       = (mseen && midx == seen) ? mrkfp_pkg::CLS_OWN_FRAG
                                              : mrkfp_pkg::CLS_OTHER_FRAG;
          frem_next = frem - 16'd1;
          if (frem_next == 16'd0) fin = 1'b1;
        end
        PH_TAIL: begin
          if (tail < 33'(mrkfp_pkg::IV_BYTES)) cls = mrkfp_pkg::CLS_IV;
          else if (tail < 33'(hlv))           cls = mrkfp_pkg::CLS_CIPHER;
          else if (tail < tag_end)            cls = mrkfp_pkg::CLS_TAG;
          else                                cls = mrkfp_pkg::CLS_DISCARD;
          if (tail != '1) tail_next = tail + 33'd1;
        end
        PH_HDR: ;
      endcase
    end

    // End of a recipient entry: next entry or the tail.
    if (fin) begin
      seen_next = seen + CW'(1);
      if (seen_next >= total) begin
        if (!mseen_next) err_next = mrkfp_pkg::ST_NO_MATCH;
        tail_next  = '0;
        phase_next = PH_TAIL;
      end else begin
        phase_next = PH_LEN;
      end
    end
  end

  // Final status, judged on the state after this byte.
  always_comb begin
    priority if (phase_next == PH_HDR)      sts = mrkfp_pkg::ST_SHORT;
    else if (err_next != mrkfp_pkg::ST_OK)  sts = err_next;
    else if (phase_next != PH_TAIL)         sts = mrkfp_pkg::ST_TRUNCATED;
    else if (tail_next != tag_end)          sts = mrkfp_pkg::ST_TAIL_LENGTH;
    else if (hlv < 32'(mrkfp_pkg::IV_BYTES)) sts = mrkfp_pkg::ST_DATA_SHORT;
    else                                    sts = mrkfp_pkg::ST_OK;
  end

  assign ridx_ext = IW'(ridx);
  assign midx_ext = IW'(midx_next);

  always_comb begin
    res.byte_out        = wire_byte;
    res.byte_class      = cls;
    res.recipient_index = ridx_ext[4:0];
    res.done_res        = last_byte;
    res.status          = last_byte ? sts : mrkfp_pkg::ST_OK;
    res.matched_index   = last_byte ? midx_ext[4:0] : 5'd0;
    res.data_length     = last_byte ? hlv_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      phase <= PH_HDR;
      fcnt  <= '0;
      total <= '0;
      seen  <= '0;
      hlv   <= '0;
      nlen  <= '0;
      neq   <= 1'b1;
      frem  <= '0;
      tail  <= '0;
      mseen <= 1'b0;
      midx  <= '0;
      err   <= mrkfp_pkg::ST_OK;
    end else if (step) begin
      phase <= phase_next;
      fcnt  <= fcnt_next;
      total <= total_next;
      seen  <= seen_next;
      hlv   <= hlv_next;
      nlen  <= nlen_next;
      neq   <= neq_next;
      frem  <= frem_next;
      tail  <= tail_next;
      mseen <= mseen_next;
      midx  <= midx_next;
      err   <= err_next;
    end
  end

endmodule

### sv/multi_recipient_key_frame_parser_top.sv
// ----------------------------------------------------------------------------
// multi_recipient_key_frame_parser_top
// Byte-stream labeler for multi-recipient key frames with an APB register port.
// ----------------------------------------------------------------------------
// The parser takes one message byte per cycle on the frame channel and returns
// one labeled byte per cycle on the label channel while the consumer is ready.
// Each accepted byte lands in an input register, goes through a single parse
// step (header check, entry walk with one name-character compare, tail split)
// and is held in a result register. While a finished label waits for the
// consumer, the input register still takes one more byte; after that the
// frame channel closes until the label leaves. The last byte of a message
// carries status, the last matching recipient and the header data length;
// the parser then starts over on a fresh message. There is no clearing pass
// after reset.
// Registers (64-bit, 8-byte spacing): 0x00 curve id, 0x08 station name
// length, 0x10 name characters 0..6, 0x18 name characters 7..13. Write them
// only while no transaction is in flight.
module multi_recipient_key_frame_parser_top #(
  parameter int MAX_RECIPIENTS = mrkfp_pkg::MAX_RECIPIENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  mrkfp_in_if.sink                         frame,
  mrkfp_out_if.source                      label,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mrkfp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mrkfp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mrkfp_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);

  // --- configuration registers ---------------------------------------------
  logic [1:0]  curve_id;
  logic [3:0]  name_len;
  logic [55:0] name_low;
  logic [55:0] name_high;
  mrkfp_pkg::reg_index_t reg_sel;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = mrkfp_pkg::reg_index_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_id  <= 2'd1;
      name_len  <= 4'd0;
      name_low  <= '0;
      name_high <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        mrkfp_pkg::REG_CURVE_ID:  curve_id  <= pwdata[1:0];
        mrkfp_pkg::REG_NAME_LEN:  name_len  <= pwdata[3:0];
        mrkfp_pkg::REG_NAME_LOW:  name_low  <= pwdata[55:0];
        mrkfp_pkg::REG_NAME_HIGH: name_high <= pwdata[55:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      mrkfp_pkg::REG_CURVE_ID:  prdata = 64'(curve_id);
      mrkfp_pkg::REG_NAME_LEN:  prdata = 64'(name_len);
      mrkfp_pkg::REG_NAME_LOW:  prdata = 64'(name_low);
      mrkfp_pkg::REG_NAME_HIGH: prdata = 64'(name_high);
    endcase
  end

  mrkfp_pkg::cfg_t cfg;
  assign cfg.curve_id = curve_id;
  assign cfg.name_len = name_len;
  assign cfg.name     = {name_high, name_low};  // char 0 in the low byte

  // --- two-register pipeline -----------------------------------------------
  // in_valid/in_byte/in_last: input register. res/res_valid: result register.
  // advance moves one byte through the parse step into the result register.
  logic               in_valid;
  logic [7:0]         in_byte;
  logic               in_last;
  logic               res_valid;
  logic               advance;
  mrkfp_pkg::result_t res, res_next;

  assign advance     = in_valid && (!res_valid || label.ready);
  assign frame.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame.ready) begin
      in_valid <= frame.valid;
    end
  end

  // Payload only; no reset needed.
  always_ff @(posedge clk) begin
    if (frame.ready && frame.valid) begin
      in_byte <= frame.wire_byte;
      in_last <= frame.last_byte;
    end
  end

  mrkfp_parse_core #(
    .MAX_RECIPIENTS (MAX_RECIPIENTS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .wire_byte (in_byte),
    .last_byte (in_last),
    .cfg       (cfg),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (label.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign label.valid           = res_valid;
  assign label.byte_out        = res.byte_out;
  assign label.byte_class      = res.byte_class;
  assign label.recipient_index = res.recipient_index;
  assign label.done_res        = res.done_res;
  assign label.status          = res.status;
  assign label.matched_index   = res.matched_index;
  assign label.data_length     = res.data_length;

`ifndef SYNTHESIS
  // A last byte moving through the parse step yields a done label next cycle.
  a_last_gives_done: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> res_valid && res.done_res)
    else $error("last byte did not produce a done label");

  // A stalled label keeps its contents while more bytes queue up.
  a_label_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !label.ready |=> res_valid && $stable(res))
    else $error("stalled label changed");

  // Frame channel only closes when both registers are full and stalled.
  a_ready_low_full: assert property (@(posedge clk) disable iff (rst)
    !frame.ready |-> in_valid && res_valid && !label.ready)
    else $error("frame channel blocked without a full pipeline");

  // Summary fields stay clear on labels that are not the last of a message.
  a_summary_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.done_res |->
      res.status == mrkfp_pkg::ST_OK && res.matched_index == 5'd0 &&
      res.data_length == 32'd0)
    else $error("summary fields set on a non-final label");
`endif

endmodule
